// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file gpl_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GPL_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define GPL_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("assertion failed");

`endif

// ===== rtl/gpl_pkg.sv =====
`timescale 1ns / 1ps
package gpl_pkg;

   localparam int MaxDim = 4096;
   localparam int POS_W  = $clog2(MaxDim);
   localparam int DIM_W  = POS_W + 1;
   localparam int TINT_W = 9;
   localparam int NUM_W  = TINT_W + DIM_W + 1;
   localparam int REM_W  = NUM_W + 1;
   localparam int QUO_W  = 9;
   localparam int CNT_W  = 4;
   localparam int ADDR_W = 5;
   localparam int COLOR_W = 3 * TINT_W;

   typedef enum logic [2:0] {
      REG_DIRECTION = 3'd0,
      REG_WIDTH     = 3'd1,
      REG_HEIGHT    = 3'd2,
      REG_START     = 3'd3,
      REG_END       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
   } pixel_out_type;

   // One queued job: the pixel and where it sits in the gradient.
   typedef struct packed {
      pixel_in_type           pix;
      logic [POS_W-1:0]       pos;
      logic [DIM_W-1:0]       span;
   } job_type;

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Extract one tint channel, saturating the pattern -256 to -255.
   function automatic logic signed [TINT_W-1:0] tint_of(
      input logic [COLOR_W-1:0] color, input logic [1:0] ch);
      logic [TINT_W-1:0] bits;
      begin
         case (ch)
            2'd0:    bits = color[TINT_W-1:0];
            2'd1:    bits = color[2*TINT_W-1:TINT_W];
            default: bits = color[3*TINT_W-1:2*TINT_W];
         endcase
         if (bits == {1'b1, {(TINT_W-1){1'b0}}}) begin
            bits = {1'b1, {(TINT_W-2){1'b0}}, 1'b1};
         end
         return $signed(bits);
      end
   endfunction

   // Clamp a dimension register to 1..MaxDim.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      begin
         if (v == '0) begin
            return DIM_W'(1);
         end else if (v > DIM_W'(MaxDim)) begin
            return DIM_W'(MaxDim);
         end
         return v;
      end
   endfunction

endpackage

// ===== rtl/gpl_front.sv =====
`timescale 1ns / 1ps
module gpl_front import gpl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pixel_in_type       req_data,
   input  logic               direction,
   input  logic [DIM_W-1:0]   image_width,
   input  logic [DIM_W-1:0]   image_height,
   input  queue_status_type   qstat,
   output logic               push,
   output job_type            push_job
);

   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] w, h, span, pos_raw, col_next, row_next;

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   // Classify: pick position and span, clamp a stale counter.
   always_comb begin
      w       = eff_dim(image_width);
      h       = eff_dim(image_height);
      span    = direction ? h : w;
      pos_raw = direction ? {1'b0, row_ff} : {1'b0, col_ff};
      if (pos_raw >= span) begin
         pos_raw = span - DIM_W'(1);
      end
      push_job.pix  = req_data;
      push_job.pos  = pos_raw[POS_W-1:0];
      push_job.span = span;
   end

   // Advance the raster counters on each accepted transaction.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      col_next = {1'b0, col_ff} + DIM_W'(1);
      row_next = {1'b0, row_ff} + DIM_W'(1);
      if (push) begin
         if (col_next >= w) begin
            col_in = '0;
            if (row_next >= h) begin
               row_in = '0;
            end else begin
               row_in = row_next[POS_W-1:0];
            end
         end else begin
            col_in = col_next[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== rtl/gpl_queue.sv =====
`timescale 1ns / 1ps
module gpl_queue import gpl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  job_type           push_job,
   input  logic              pop,
   output job_type           pop_job,
   output queue_status_type  qstat
);

   job_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == 2'd2);
   assign qstat.empty = (cnt_ff == 2'd0);
   assign pop_job     = mem_ff[rd_ff];

   // Move pointers and fill count.
   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/gpl_back.sv =====
`timescale 1ns / 1ps
module gpl_back import gpl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  queue_status_type    qstat,
   input  job_type             pop_job,
   output logic                pop,
   input  logic [COLOR_W-1:0]  start_color,
   input  logic [COLOR_W-1:0]  end_color,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pixel_out_type       rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_MUL  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   pixel_in_type       pix_ff;
   logic [7:0]         p [3];
   logic [REM_W-1:0]   rem_ff [3], rem_in [3];
   logic [REM_W-1:0]   dsh_ff, dsh_in;
   logic [QUO_W-1:0]   q_ff [3], q_in [3];
   logic               neg_ff [3];
   logic [15:0]        prod_ff [3];
   logic               lit_ff [3];
   logic               rsp_valid_ff, rsp_valid_in;
   pixel_out_type      rsp_data_ff;
   logic [7:0]         res [3];

   assign p[0]      = pix_ff.red_in;
   assign p[1]      = pix_ff.green_in;
   assign p[2]      = pix_ff.blue_in;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pop       = (state_ff == S_IDLE) && !qstat.empty;

   // Sequence: load, divide one quotient bit a cycle, scale, deliver.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (!qstat.empty) begin
               state_in = S_DIV;
               cnt_in   = '0;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Tint numerator and restoring division per channel.
   always_comb begin
      logic signed [NUM_W-1:0] s_x, e_x, num;
      logic [NUM_W-1:0]        mag;
      logic [DIM_W-1:0]        diff;
      s_x    = '0;
      e_x    = '0;
      num    = '0;
      mag    = '0;
      diff   = '0;
      dsh_in = dsh_ff >> 1;
      for (int c = 0; c < 3; c++) begin
         rem_in[c] = rem_ff[c];
         q_in[c]   = q_ff[c];
      end
      if (state_ff == S_IDLE) begin
         dsh_in = REM_W'({pop_job.span, 1'b0}) << (QUO_W - 1);
         diff   = pop_job.span - DIM_W'(pop_job.pos);
         for (int c = 0; c < 3; c++) begin
            s_x = NUM_W'(tint_of(start_color, 2'(c)));
            e_x = NUM_W'(tint_of(end_color, 2'(c)));
            num = s_x * $signed(NUM_W'(diff)) + e_x * $signed(NUM_W'(pop_job.pos));
            mag = num[NUM_W-1] ? -num : num;
            rem_in[c] = REM_W'({mag, 1'b0}) + REM_W'(pop_job.span);
            q_in[c]   = '0;
         end
      end else if (state_ff == S_DIV) begin
         for (int c = 0; c < 3; c++) begin
            if (rem_ff[c] >= dsh_ff) begin
               rem_in[c] = rem_ff[c] - dsh_ff;
               q_in[c]   = {q_ff[c][QUO_W-2:0], 1'b1};
            end else begin
               q_in[c]   = {q_ff[c][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dsh_ff <= dsh_in;
      for (int c = 0; c < 3; c++) begin
         rem_ff[c] <= rem_in[c];
         q_ff[c]   <= q_in[c];
      end
   end

   // Latch the pixel and tint signs when the job leaves the queue.
   always_ff @(posedge clock) begin
      if (pop) begin
         pix_ff <= pop_job.pix;
         for (int c = 0; c < 3; c++) begin
            neg_ff[c] <= (NUM_W'(tint_of(start_color, 2'(c))) * $signed(NUM_W'(
                          pop_job.span - DIM_W'(pop_job.pos)))
                          + NUM_W'(tint_of(end_color, 2'(c)))
                          * $signed(NUM_W'(pop_job.pos))) < 0;
         end
      end
   end

   // Scale: darken p*(255-q), lighten (255-p)*q.
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         for (int c = 0; c < 3; c++) begin
            if (neg_ff[c]) begin
               prod_ff[c] <= p[c] * (8'd255 - q_ff[c][7:0]);
               lit_ff[c]  <= 1'b0;
            end else begin
               prod_ff[c] <= (8'd255 - p[c]) * q_ff[c][7:0];
               lit_ff[c]  <= 1'b1;
            end
         end
      end
   end

   // Divide by 255 with the shift-and-add form, exact for every 8-bit by 8-bit product.
   always_comb begin
      logic [16:0] t;
      for (int c = 0; c < 3; c++) begin
         t = 17'(prod_ff[c]) + 17'(prod_ff[c] >> 8) + 17'd1;
         res[c] = lit_ff[c] ? p[c] + t[15:8] : t[15:8];
      end
   end

   // Hold the result until the transaction is taken.
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff.red_out   <= res[0];
         rsp_data_ff.green_out <= res[1];
         rsp_data_ff.blue_out  <= res[2];
         rsp_data_ff.alpha_out <= pix_ff.alpha_in;
      end
   end

endmodule

// ===== rtl/pixel_gradient_lighten_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                         Handshake
// request   req_valid/req_stall/req_data  accept: valid && !stall
// response  rsp_valid/rsp_stall/rsp_data  accept: valid && !stall
// config    csr_psel..csr_prdata          write: psel && penable && pwrite
//
// In the back part each pixel goes through a load, the bit-serial divider that
// rounds the tint, a multiply and a delivery before the next is popped.
// The front takes a pixel each cycle into a two-entry queue until it fills.
// Reset clears counters, queue pointers, state, config; no clearing pass.
// A stalled response holds its register; the queue takes input until full.
module pixel_gradient_lighten_core import gpl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pixel_in_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pixel_out_type      rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic                dir_ff;
   logic [DIM_W-1:0]    width_ff, height_ff;
   logic [COLOR_W-1:0]  start_ff, end_ff;
   reg_index_type       idx;
   logic                wr_en;
   queue_status_type    qstat;
   logic                push, pop;
   job_type             push_job, pop_job;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Write configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff    <= 1'b0;
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         start_ff  <= '0;
         end_ff    <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_DIRECTION: dir_ff    <= csr_pwdata[0];
            REG_WIDTH:     width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_HEIGHT:    height_ff <= csr_pwdata[DIM_W-1:0];
            REG_START:     start_ff  <= csr_pwdata[COLOR_W-1:0];
            REG_END:       end_ff    <= csr_pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (idx)
         REG_DIRECTION: csr_prdata = 32'(dir_ff);
         REG_WIDTH:     csr_prdata = 32'(width_ff);
         REG_HEIGHT:    csr_prdata = 32'(height_ff);
         REG_START:     csr_prdata = 32'(start_ff);
         REG_END:       csr_prdata = 32'(end_ff);
         default:       csr_prdata = '0;
      endcase
   end

   gpl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .direction    (dir_ff),
      .image_width  (width_ff),
      .image_height (height_ff),
      .qstat        (qstat),
      .push         (push),
      .push_job     (push_job)
   );

   gpl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .qstat    (qstat)
   );

   gpl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .qstat       (qstat),
      .pop_job     (pop_job),
      .pop         (pop),
      .start_color (start_ff),
      .end_color   (end_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== rtl/gpl_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpl_checker import gpl_pkg::*; (
   input logic           clock,
   input logic           reset,
   input logic           rsp_valid,
   input logic           rsp_stall,
   input pixel_out_type  rsp_data,
   input logic           csr_pready
);

   // A stalled result stays offered.
   `GPL_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid)
   // A stalled result does not change.
   `GPL_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_data))
   // Reset empties the output register.
   `GPL_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid)
   // The register port never waits.
   `GPL_ASSERT_ALWAYS(a_pready, csr_pready)

endmodule

bind pixel_gradient_lighten_core gpl_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);
